// ===== rtl/core/mpa_pkg.sv =====
// Shared types and constants for the 2x2 max pooling block with argmax.
// No dependencies; every module of the block imports this package.
package mpa_pkg;

  // Default geometry and sample precision
  localparam int DEF_MAP_WIDTH   = 28;
  localparam int DEF_CHANNELS    = 5;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths of the streams
  localparam int SAMPLE_W  = 16;
  localparam int DENSE_W   = 10;
  localparam int CHAN_W    = 3;
  localparam int POS_W     = 5;
  localparam int OUT_DATA_W = 40;

  // Depth of the queue between the front and back parts (power of two)
  localparam int QUEUE_DEPTH = 4;

  // One window waiting for its final compare
  typedef struct packed {
    logic [SAMPLE_W-1:0] pair_max;   // maximum of the bottom pair
    logic                pair_right; // right bottom sample won its pair
    logic [SAMPLE_W-1:0] top_max;    // maximum of the top pair
    logic                top_right;  // right top sample won its pair
    logic [POS_W-1:0]    row;        // row of the bottom pair, truncated
    logic [POS_W-1:0]    col;        // column of the right sample, truncated
    logic [CHAN_W-1:0]   channel;
    logic [DENSE_W-1:0]  dense;
    logic                last;
  } work_t;

  // One finished result
  typedef struct packed {
    logic                last;
    logic [POS_W-1:0]    argmax_col;
    logic [POS_W-1:0]    argmax_row;
    logic [CHAN_W-1:0]   channel;
    logic [DENSE_W-1:0]  dense;
    logic [SAMPLE_W-1:0] pooled;
  } result_t;

endpackage

// ===== rtl/core/max_pool_2x2_argmax.sv =====
// Top level of 2x2 stride-2 max pooling with argmax position.
// Depends on mpa_pkg, mpa_front, mpa_queue and mpa_back.
//
//   channel  dir  transaction
//   s_axis   in   one activation sample, raster order channel, row, column
//   m_axis   out  one pooled window: maximum, dense index, channel, argmax
//
// Without stalls one sample is accepted every cycle; the front path, the queue
// and the output register each run at one transaction per clock.
// m_axis_tvalid rises once the window's closing sample has passed the stage
// register, the queue and the output register, in that order.
// Synchronous reset clears the position counters, queue and valid flags.
// The line store of top pairs needs no clearing; it is written before read.
// A stalled m_axis fills the queue, then drops s_axis_tready.
module max_pool_2x2_argmax #(
  parameter int MAP_WIDTH   = mpa_pkg::DEF_MAP_WIDTH,
  parameter int CHANNELS    = mpa_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mpa_pkg::DEF_SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sample_value[15:0]
  input  logic [mpa_pkg::SAMPLE_W-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // pooled_value[15:0], dense_index[25:16], channel_number[28:26],
  // argmax_row[33:29], argmax_col[38:34], zero[39]
  output logic [mpa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // last_of_frame
  output logic                            m_axis_tlast
);
  import mpa_pkg::*;

  logic    push_valid;
  logic    push_ready;
  work_t   push_item;
  logic    pop_valid;
  logic    pop_ready;
  work_t   pop_item;
  result_t out_result;

  mpa_front #(
    .MAP_WIDTH  (MAP_WIDTH),
    .CHANNELS   (CHANNELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item)
  );

  mpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item)
  );

  mpa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_result(out_result)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {1'b0, out_result.argmax_col, out_result.argmax_row,
                         out_result.channel, out_result.dense, out_result.pooled};
  assign m_axis_tlast = out_result.last;

endmodule

// ===== rtl/core/mpa_front.sv =====
// Front part: accepts samples, tracks the raster position, forms pair maxima
// and keeps the top-pair line store. Depends on mpa_pkg.
module mpa_front #(
  parameter int MAP_WIDTH   = mpa_pkg::DEF_MAP_WIDTH,
  parameter int CHANNELS    = mpa_pkg::DEF_CHANNELS,
  parameter int SAMPLE_BITS = mpa_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mpa_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mpa_pkg::work_t                push_item
);
  import mpa_pkg::*;

  localparam int SW       = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int CW       = $clog2(MAP_WIDTH);
  localparam int CHW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HALF     = MAP_WIDTH / 2;
  localparam int SLW      = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int LAST_WIN = HALF * 2 - 1;

  // Position of the next sample and the previous sample
  logic [CW-1:0]      col;
  logic [CW-1:0]      row;
  logic [CHW-1:0]     chan;
  logic [DENSE_W-1:0] out_count;
  logic [SW-1:0]      left_sample;

  // Line store of top pairs
  logic [SW-1:0] top_max_mem  [HALF];
  logic          top_pick_mem [HALF];
  logic [SW-1:0] rd_max;
  logic          rd_pick;

  // Stage register of a window waiting for the queue
  logic               s1_valid;
  logic [SW-1:0]      s1_pair_max;
  logic               s1_right;
  logic [POS_W-1:0]   s1_row;
  logic [POS_W-1:0]   s1_col;
  logic [CHAN_W-1:0]  s1_chan;
  logic [DENSE_W-1:0] s1_dense;
  logic               s1_last;

  logic               accept;
  logic [SW-1:0]      sample;
  logic               right;
  logic [SW-1:0]      pair_max;
  logic [CW-1:0]      col_half;
  logic [SLW-1:0]     slot;
  logic               in_window;
  logic               pair_done;
  logic               top_write;
  logic               is_result;
  logic               col_last;
  logic               row_last;
  logic               chan_last;
  logic               frame_last;
  logic               win_last;
  logic [CW+4:0]      row_x;
  logic [CW+4:0]      col_x;
  logic [CHW+2:0]     chan_x;

  // Classify the incoming sample
  always_comb begin
    accept     = in_valid && in_ready;
    sample     = in_sample[SW-1:0];
    right      = sample > left_sample;
    pair_max   = right ? sample : left_sample;
    col_half   = col >> 1;
    slot       = col_half[SLW-1:0];
    in_window  = (row <= CW'(LAST_WIN)) && (col <= CW'(LAST_WIN));
    pair_done  = in_window && col[0];
    top_write  = accept && pair_done && !row[0];
    is_result  = pair_done && row[0];
    col_last   = col == CW'(MAP_WIDTH - 1);
    row_last   = row == CW'(MAP_WIDTH - 1);
    chan_last  = chan == CHW'(CHANNELS - 1);
    frame_last = col_last && row_last && chan_last;
    // final window of the frame; an odd map leaves a row and column after it
    win_last   = chan_last && (row == CW'(LAST_WIN)) && (col == CW'(LAST_WIN));
    row_x      = (CW + 5)'(row);
    col_x      = (CW + 5)'(col);
    chan_x     = (CHW + 3)'(chan);
  end

  assign in_ready = !s1_valid || push_ready;

  // Advance the raster position and the result count
  always_ff @(posedge clk) begin
    if (rst) begin
      col         <= '0;
      row         <= '0;
      chan        <= '0;
      out_count   <= '0;
      left_sample <= '0;
    end else if (accept) begin
      left_sample <= sample;
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row  <= '0;
          chan <= chan_last ? '0 : chan + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
      if (frame_last) begin
        out_count <= '0;
      end else if (is_result) begin
        out_count <= out_count + 1'b1;
      end
    end
  end

  // Write top pairs, read them back for the bottom pair
  always_ff @(posedge clk) begin
    if (top_write) begin
      top_max_mem[slot]  <= pair_max;
      top_pick_mem[slot] <= right;
    end
    if (accept && is_result) begin
      rd_max  <= top_max_mem[slot];
      rd_pick <= top_pick_mem[slot];
    end
  end

  // Hold a window until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && is_result) begin
      s1_valid <= 1'b1;
    end else if (push_ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_result) begin
      s1_pair_max <= pair_max;
      s1_right    <= right;
      s1_row      <= row_x[POS_W-1:0];
      s1_col      <= col_x[POS_W-1:0];
      s1_chan     <= chan_x[CHAN_W-1:0];
      s1_dense    <= out_count;
      s1_last     <= win_last;
    end
  end

  // Assemble the queue entry
  always_comb begin
    push_valid           = s1_valid;
    push_item.pair_max   = SAMPLE_W'(s1_pair_max);
    push_item.pair_right = s1_right;
    push_item.top_max    = SAMPLE_W'(rd_max);
    push_item.top_right  = rd_pick;
    push_item.row        = s1_row;
    push_item.col        = s1_col;
    push_item.channel    = s1_chan;
    push_item.dense      = s1_dense;
    push_item.last       = s1_last;
  end

endmodule

// ===== rtl/core/mpa_queue.sv =====
// Short queue of pending windows between the front and back parts.
// Depends on mpa_pkg for the entry type and depth.
module mpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  mpa_pkg::work_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output mpa_pkg::work_t pop_item
);
  import mpa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  work_t          entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;
  logic           push;
  logic           pop;

  always_comb begin
    push_ready = count != (PW + 1)'(QUEUE_DEPTH);
    pop_valid  = count != '0;
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
    pop_item   = entries[rd_ptr];
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/mpa_back.sv =====
// Back part: final top/bottom compare of each window and the output register.
// Depends on mpa_pkg.
module mpa_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  mpa_pkg::work_t   pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output mpa_pkg::result_t out_result
);
  import mpa_pkg::*;

  logic    pop;
  logic    bottom;
  result_t result_next;

  // Pick the window winner; ties keep the top pair
  always_comb begin
    pop                    = pop_valid && pop_ready;
    bottom                 = pop_item.pair_max > pop_item.top_max;
    result_next.pooled     = bottom ? pop_item.pair_max : pop_item.top_max;
    result_next.dense      = pop_item.dense;
    result_next.channel    = pop_item.channel;
    result_next.argmax_row = {pop_item.row[POS_W-1:1], bottom};
    result_next.argmax_col = {pop_item.col[POS_W-1:1],
                              bottom ? pop_item.pair_right : pop_item.top_right};
    result_next.last       = pop_item.last;
  end

  assign pop_ready = !out_valid || out_ready;

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result_next;
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench for max_pool_2x2_argmax: streams activation samples and checks
// each pooled window against a pooling and argmax predictor or a typed result.
// Depends on mpa_pkg and the max_pool_2x2_argmax RTL.
module tb_top;
  import mpa_pkg::*;

  localparam int MAP_W          = DEF_MAP_WIDTH;
  localparam int CHANS          = DEF_CHANNELS;
  localparam int HALF_W         = MAP_W / 2;
  localparam int LAST_WIN       = HALF_W * 2 - 1;
  // random samples after the directed first window row, about 1200 in all
  localparam int RANDOM_SAMPLES = 1144;
  localparam int QUIET_TAIL     = 200;
  localparam int HOLD_AT        = 300;
  localparam int PAUSE_AT       = 700;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 16;
  localparam int CYCLE_LIMIT    = 500000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = (DEF_SAMPLE_BITS >= SAMPLE_W) ?
      {SAMPLE_W{1'b1}} : SAMPLE_W'((64'd1 << DEF_SAMPLE_BITS) - 1);

  typedef enum int {TOP_LEFT, TOP_RIGHT, BOTTOM_LEFT, BOTTOM_RIGHT} corner_e;

  typedef struct {
    logic [SAMPLE_W-1:0] tl, tr, bl, br;
    logic [SAMPLE_W-1:0] peak;
    corner_e             winner;
  } window_case_t;

  // Directed windows of the first window row, channel 0
  window_case_t window_table [HALF_W] = '{
    '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, TOP_LEFT},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, TOP_LEFT},
    '{16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, TOP_LEFT},
    '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, TOP_RIGHT},
    '{16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, BOTTOM_LEFT},
    '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, BOTTOM_RIGHT},
    '{16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0005, TOP_LEFT},
    '{16'h0001, 16'h0002, 16'h0002, 16'h0002, 16'h0002, TOP_RIGHT},
    '{16'h0001, 16'h0001, 16'h0002, 16'h0002, 16'h0002, BOTTOM_LEFT},
    '{16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h0002, BOTTOM_RIGHT},
    '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, TOP_LEFT},
    '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA, TOP_LEFT},
    '{16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'hAAAA, TOP_RIGHT},
    '{16'h0001, 16'h0000, 16'hFFFE, 16'hFFFF, 16'hFFFF, BOTTOM_RIGHT}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  // Predictor state: line of top pairs, previous sample, raster position
  logic [SAMPLE_W-1:0] top_max_line [HALF_W];
  bit                  top_right_line [HALF_W];
  logic [SAMPLE_W-1:0] left_val = '0;
  int                  chan_pos = 0;
  int                  row_pos = 0;
  int                  col_pos = 0;
  int                  window_count = 0;

  result_t expected_windows [$];
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      hold_output = 1'b0;
  bit      quiet_tail = 1'b0;

  max_pool_2x2_argmax dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Advance the pooling predictor by one sample; return 1 when a window closes
  function automatic bit pool_sample(input logic [SAMPLE_W-1:0] raw, output result_t win);
    logic [SAMPLE_W-1:0] s, pair_peak, top_peak;
    bit right_wins, bottom_wins, closes;
    int slot;
    s = raw & SAMPLE_MASK;
    slot = col_pos / 2;
    closes = 1'b0;
    win = '0;
    if (row_pos <= LAST_WIN && col_pos <= LAST_WIN && col_pos % 2 == 1 && slot < HALF_W) begin
      // right sample takes the pair only when strictly greater
      right_wins = s > left_val;
      pair_peak = right_wins ? s : left_val;
      if (row_pos % 2 == 0) begin
        top_max_line[slot] = pair_peak;
        top_right_line[slot] = right_wins;
      end else begin
        top_peak = top_max_line[slot];
        bottom_wins = pair_peak > top_peak;
        win.pooled = bottom_wins ? pair_peak : top_peak;
        win.dense = DENSE_W'(window_count);
        win.channel = CHAN_W'(chan_pos);
        win.argmax_row = POS_W'(bottom_wins ? row_pos : row_pos - 1);
        win.argmax_col = POS_W'(col_pos - 1 +
            (bottom_wins ? int'(right_wins) : int'(top_right_line[slot])));
        win.last = (chan_pos == CHANS - 1) && (row_pos == LAST_WIN) && (col_pos == LAST_WIN);
        window_count++;
        closes = 1'b1;
      end
    end
    left_val = s;
    // step the raster position, wrapping the frame
    col_pos++;
    if (col_pos >= MAP_W) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= MAP_W) begin
        row_pos = 0;
        chan_pos++;
        if (chan_pos >= CHANS) begin
          chan_pos = 0;
          window_count = 0;
        end
      end
    end
    return closes;
  endfunction

  // Bias toward extremes and small values so ties come up often
  function automatic logic [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return SAMPLE_W'($urandom_range(0, 3));
      4: return SAMPLE_W'($urandom_range(16'hFFFC, 16'hFFFF));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer one sample, hold it until accepted, then queue its window if any
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit typed,
                             input result_t typed_win);
    result_t predicted;
    s_axis_tdata <= value;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (pool_sample(value, predicted)) begin
      expected_windows.push_back(typed ? typed_win : predicted);
    end
  endtask

  task automatic idle_source(input int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Compare each output transaction with the oldest expected window
  always @(posedge clk) begin : window_check
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_windows.size() == 0) begin
        $error("unexpected window: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
        mismatches++;
      end else begin
        want = expected_windows.pop_front();
        check_field("pooled_value", want.pooled, m_axis_tdata[15:0]);
        check_field("dense_index", want.dense, m_axis_tdata[25:16]);
        check_field("channel_number", want.channel, m_axis_tdata[28:26]);
        check_field("argmax_row", want.argmax_row, m_axis_tdata[33:29]);
        check_field("argmax_col", want.argmax_col, m_axis_tdata[38:34]);
        check_field("tdata pad", 0, m_axis_tdata[39]);
        check_field("last_of_frame", want.last, m_axis_tlast);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Drive m_axis_tready: random stall bursts, one long hold, none at the tail
  initial begin : result_sink
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
        hold_output = 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 17);
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    result_t typed_win;
    bit right_corner, bottom_corner;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: top pairs of all windows, then bottom pairs with typed results
    for (int w = 0; w < HALF_W; w++) begin
      send_sample(window_table[w].tl, 1'b0, '0);
      send_sample(window_table[w].tr, 1'b0, '0);
    end
    for (int w = 0; w < HALF_W; w++) begin
      right_corner = window_table[w].winner inside {TOP_RIGHT, BOTTOM_RIGHT};
      bottom_corner = window_table[w].winner inside {BOTTOM_LEFT, BOTTOM_RIGHT};
      typed_win = '0;
      typed_win.pooled = window_table[w].peak;
      typed_win.dense = DENSE_W'(w);
      typed_win.argmax_row = POS_W'(bottom_corner);
      typed_win.argmax_col = POS_W'(2 * w + int'(right_corner));
      send_sample(window_table[w].bl, 1'b0, '0);
      send_sample(window_table[w].br, 1'b1, typed_win);
    end

    // Random: one long output hold and one drain along the way
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      quiet_tail = (i >= RANDOM_SAMPLES - QUIET_TAIL);
      if (i == HOLD_AT) hold_output = 1'b1;
      if (i == PAUSE_AT) begin
        s_axis_tvalid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end else if (!quiet_tail && !hold_output && $urandom_range(0, 7) == 0) begin
        idle_source($urandom_range(1, 17));
      end
      send_sample(random_sample(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
